// File: rtl/q2e_pkg.sv
// Shared constants, tables and types for the quaternion to Euler angle converter.
package q2e_pkg;

    // Requested CORDIC stage count; anything above the table length runs as the table length.
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 30;
    localparam int NST           = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    // CORDIC latency: quadrant stage, rotation stages, clamp, multiply and rounding.
    localparam int CORDIC_LAT = NST + 4;

    // Square root: one result bit per stage over a 57-bit radicand.
    localparam int SQ_W       = 57;
    localparam int ISQ_STAGES = 29;
    localparam int ROOT_W     = 29;

    // Operand widths.
    localparam int IN_W  = 34;
    localparam int XY_W  = 52;
    localparam int ANG_W = 32;
    localparam int OUT_W = 25;
    localparam int S_W   = 30;

    // Angles are in units of 2^-28 rad.
    localparam int ANG_PI   = 843314857;
    localparam int ONE_Q28  = 268435456;
    localparam int HALF_Q28 = 134217728;
    localparam int DEG_MUL  = 961263669;

    // atan(2^-i) rounded to the nearest 2^-28 rad; the first entry is pi/4.
    localparam int ATAN_TAB [MAX_STAGES] = '{
        210828714, 124459457, 65760959, 33381290, 16755422,
        8385879,   4193963,   2097109,  1048571,  524287,
        262144,    131072,    65536,    32768,    16384,
        8192,      4096,      2048,     1024,     512,
        256,       128,       64,       32,       16,
        8,         4,         2,        1,        0
    };

    // Words that travel alongside the square root.
    typedef struct packed {
        logic signed [IN_W-1:0] roll_y;
        logic signed [IN_W-1:0] roll_x;
        logic signed [IN_W-1:0] yaw_y;
        logic signed [IN_W-1:0] yaw_x;
        logic signed [S_W-1:0]  s;
        logic                   clamped;
    } pass_t;

endpackage

// File: rtl/q2e_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
module q2e_isqrt
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [q2e_pkg::SQ_W-1:0]      v_in,
    output logic [q2e_pkg::ROOT_W-1:0]    root
);
    import q2e_pkg::*;

    logic [SQ_W-1:0] v_reg [0:ISQ_STAGES-1];
    logic [SQ_W+1:0] r_reg [0:ISQ_STAGES-1];

    genvar k;
    generate
        for (k = 0; k < ISQ_STAGES; k++)
        begin : g_stage
            logic [SQ_W-1:0] v_prev;
            logic [SQ_W+1:0] r_prev;
            logic [SQ_W+1:0] bit_val;
            logic [SQ_W+1:0] trial;
            logic [SQ_W-1:0] v_next;
            logic [SQ_W+1:0] r_next;

            if (k == 0)
            begin : g_first
                assign v_prev = v_in;
                assign r_prev = '0;
            end
            else
            begin : g_rest
                assign v_prev = v_reg[k-1];
                assign r_prev = r_reg[k-1];
            end

            // Subtract the trial value where it fits and set the root bit.
            always_comb
            begin
                bit_val = (SQ_W+2)'(1) << (SQ_W - 1 - 2 * k);
                trial   = r_prev + bit_val;
                if ({2'b00, v_prev} >= trial)
                begin
                    v_next = v_prev - trial[SQ_W-1:0];
                    r_next = (r_prev >> 1) + bit_val;
                end
                else
                begin
                    v_next = v_prev;
                    r_next = r_prev >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k] <= v_next;
                    r_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

// File: rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC atan2 with clamping and unit scaling.
module q2e_cordic
(
    input  logic                                clk,
    input  logic                                en,
    input  logic                                angle_unit,
    input  logic signed [q2e_pkg::IN_W-1:0]     y_in,
    input  logic signed [q2e_pkg::IN_W-1:0]     x_in,
    output logic signed [q2e_pkg::OUT_W-1:0]    angle
);
    import q2e_pkg::*;

    logic signed [XY_W-1:0]  x_reg [0:NST];
    logic signed [XY_W-1:0]  y_reg [0:NST];
    logic signed [ANG_W-1:0] a_reg [0:NST];
    logic                    zero_reg [0:NST];

    logic signed [XY_W-1:0]  x0_next;
    logic signed [XY_W-1:0]  y0_next;
    logic signed [ANG_W-1:0] a0_next;

    logic signed [ANG_W-2:0] ac_reg;
    logic signed [ANG_W-2:0] ac_next;
    logic signed [ANG_W-2:0] rad_reg;
    logic signed [62:0]      prod_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic signed [OUT_W-1:0] angle_next;
    logic signed [ANG_W-1:0] rad_sum;
    logic signed [62:0]      deg_sum;

    // Prescale and fold the left half plane onto the right.
    always_comb
    begin
        x0_next = XY_W'(x_in) <<< 16;
        y0_next = XY_W'(y_in) <<< 16;
        a0_next = '0;
        if (x_in < 0)
        begin
            a0_next = (y_in >= 0) ? ANG_W'(ANG_PI) : -ANG_W'(ANG_PI);
            x0_next = -x0_next;
            y0_next = -y0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            a_reg[0]    <= a0_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    // Rotation stages.
    genvar i;
    generate
        for (i = 0; i < NST; i++)
        begin : g_rot
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        a_reg[i+1] <= a_reg[i] + ANG_W'(ATAN_TAB[i]);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        a_reg[i+1] <= a_reg[i] - ANG_W'(ATAN_TAB[i]);
                    end
                end
            end
        end
    endgenerate

    // Clamp to plus or minus pi; a zero vector gives zero.
    always_comb
    begin
        if (zero_reg[NST])
            ac_next = '0;
        else if (a_reg[NST] > ANG_W'(ANG_PI))
            ac_next = (ANG_W-1)'(ANG_PI);
        else if (a_reg[NST] < -ANG_W'(ANG_PI))
            ac_next = -(ANG_W-1)'(ANG_PI);
        else
            ac_next = (ANG_W-1)'(a_reg[NST]);
    end

    // Scaling and rounding to the output format.
    always_comb
    begin
        rad_sum = ANG_W'(rad_reg) + ANG_W'(2048);
        deg_sum = prod_reg + (63'sd1 <<< 35);
        if (angle_unit)
            angle_next = OUT_W'(deg_sum >>> 36);
        else
            angle_next = OUT_W'(rad_sum >>> 12);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg    <= ac_next;
            prod_reg  <= 63'(ac_reg) * 63'(DEG_MUL);
            rad_reg   <= ac_reg;
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Top level: quaternion to roll, pitch and yaw converter.
//
// One quaternion word is taken in every cycle in which no finished word waits;
// its angles pass the product, operand, sine-square and one-minus stages, the
// 29-stage square root for the pitch cosine and the CORDIC rotation pipelines
// that follow it. The whole pipeline holds while an output word waits, empty
// slots included, so s_tready is low in every cycle in which a finished word is
// offered and not taken. angle_unit is read at the rounding stage and should be
// written only while the block is empty.
module quaternion_to_euler_angles
(
    input  logic        clk,
    input  logic        rst_n,
    // Input word: quat_w, quat_x, quat_y, quat_z, 16 bits each from bit 0 up.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Output word: roll_angle, pitch_angle, yaw_angle, 25 bits each from bit 0 up.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    // Output flag: pitch_clamped.
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import q2e_pkg::*;

    localparam int PASS_LEN = ISQ_STAGES + 3;
    localparam int LAT      = 4 + ISQ_STAGES + CORDIC_LAT;

    logic en;
    logic angle_unit_reg;
    logic vld_reg [0:LAT-1];

    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, xz_reg, xy_reg, wz_reg, zz_reg;

    logic signed [34:0] s_full;
    pass_t              pass_next;
    pass_t              pass_reg [0:PASS_LEN-1];
    logic signed [2*S_W-1:0] s_sq;
    logic [SQ_W-1:0]    ss_reg;
    logic [SQ_W-1:0]    v_reg;
    logic [ROOT_W-1:0]  root;
    logic               clamp_reg [0:CORDIC_LAT-1];

    logic signed [OUT_W-1:0] roll_angle, pitch_angle, yaw_angle;

    // The whole pipeline advances unless a finished word is waiting.
    assign en        = m_tready || !vld_reg[LAT-1];
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign quat_w = s_tdata[15:0];
    assign quat_x = s_tdata[31:16];
    assign quat_y = s_tdata[47:32];
    assign quat_z = s_tdata[63:48];

    // Unit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_unit_reg <= 1'b1;
        else if (cfg_valid)
            angle_unit_reg <= cfg_data;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Stage one: the nine quaternion products needed, exact in Q4.28.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wy_reg <= quat_w * quat_y;
            xz_reg <= quat_x * quat_z;
            xy_reg <= quat_x * quat_y;
            wz_reg <= quat_w * quat_z;
            zz_reg <= quat_z * quat_z;
        end
    end

    // Stage two: atan2 operands and the clamped asin argument.
    always_comb
    begin
        s_full = (35'(wy_reg) - 35'(xz_reg)) <<< 1;
        pass_next.roll_y  = IN_W'(wx_reg) + IN_W'(yz_reg);
        pass_next.roll_x  = IN_W'(HALF_Q28) - IN_W'(xx_reg) - IN_W'(yy_reg);
        pass_next.yaw_y   = IN_W'(xy_reg) + IN_W'(wz_reg);
        pass_next.yaw_x   = IN_W'(HALF_Q28) - IN_W'(yy_reg) - IN_W'(zz_reg);
        pass_next.clamped = 1'b0;
        if (s_full > 35'(ONE_Q28))
        begin
            pass_next.s       = S_W'(ONE_Q28);
            pass_next.clamped = 1'b1;
        end
        else if (s_full < -35'(ONE_Q28))
        begin
            pass_next.s       = -S_W'(ONE_Q28);
            pass_next.clamped = 1'b1;
        end
        else
        begin
            pass_next.s = S_W'(s_full);
        end
    end

    // Side words follow the square root pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg[0] <= pass_next;
            for (int k = 1; k < PASS_LEN; k++)
                pass_reg[k] <= pass_reg[k-1];
        end
    end

    // Full-width square of the clamped sine.
    assign s_sq = pass_reg[0].s * pass_reg[0].s;

    // Stages three and four: square of the sine, then one minus it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= s_sq[SQ_W-1:0];
            v_reg  <= (SQ_W'(1) << (SQ_W - 1)) - ss_reg;
        end
    end

    q2e_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .v_in (v_reg),
        .root (root)
    );

    q2e_cordic u_roll
    (
        .clk        (clk),
        .en         (en),
        .angle_unit (angle_unit_reg),
        .y_in       (pass_reg[PASS_LEN-1].roll_y),
        .x_in       (pass_reg[PASS_LEN-1].roll_x),
        .angle      (roll_angle)
    );

    q2e_cordic u_pitch
    (
        .clk        (clk),
        .en         (en),
        .angle_unit (angle_unit_reg),
        .y_in       (IN_W'(pass_reg[PASS_LEN-1].s)),
        .x_in       (IN_W'(root)),
        .angle      (pitch_angle)
    );

    q2e_cordic u_yaw
    (
        .clk        (clk),
        .en         (en),
        .angle_unit (angle_unit_reg),
        .y_in       (pass_reg[PASS_LEN-1].yaw_y),
        .x_in       (pass_reg[PASS_LEN-1].yaw_x),
        .angle      (yaw_angle)
    );

    // Clamp flag follows the CORDIC pipelines.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_reg[0] <= pass_reg[PASS_LEN-1].clamped;
            for (int k = 1; k < CORDIC_LAT; k++)
                clamp_reg[k] <= clamp_reg[k-1];
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {5'b00000, yaw_angle, pitch_angle, roll_angle};
    assign m_tuser  = clamp_reg[CORDIC_LAT-1];

    // An accepted word occupies the first stage on the next edge.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    // A stall freezes the output word and flag.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed during a stall");

    // A stall freezes the valid line at the first stage.
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> vld_reg[0] == $past(vld_reg[0]))
        else $error("valid line moved during a stall");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the quaternion to Euler angle converter.
module tb;
    import q2e_pkg::*;

    localparam int LATENCY   = 4 + 29 + NST + 4;
    localparam int LIMIT     = 2000000;
    localparam int N_RANDOM  = 1900;

    // One expected output word.
    typedef struct {
        logic [24:0] roll;
        logic [24:0] pitch;
        logic [24:0] yaw;
        logic        clamped;
    } angles_t;

    // One row of directed stimulus; has_fixed marks rows with typed-in results.
    typedef struct {
        logic [15:0] w, x, y, z;
        bit          has_fixed;
        angles_t     fixed;
    } quat_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    angles_t     angles_q[$];
    bit          unit_deg;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          mismatches;
    int          cycle_count;
    longint      atan_lut[MAX_STAGES];

    quaternion_to_euler_angles u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Arctangent table built from the alternating series, rounded to 2^-28 rad.
    function automatic void build_atan_lut();
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned term;
        int e;
        atan_lut[0] = 210828714;
        for (int i = 1; i < MAX_STAGES; i++)
        begin
            pos = 0;
            neg = 0;
            for (int k = 0; ; k++)
            begin
                e = 60 - i * (2 * k + 1);
                if (e < 0)
                    break;
                term = (64'd1 << e) / longint'(2 * k + 1);
                if (k & 1)
                    neg += term;
                else
                    pos += term;
            end
            atan_lut[i] = longint'((pos - neg + (64'd1 << 31) - 1) >> 32);
        end
    endfunction

    // Exact floor square root.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC arctangent in units of 2^-28 rad, clamped to +-pi.
    function automatic longint vector_angle(longint y, longint x);
        longint a;
        longint dx;
        longint dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            a = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NST; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                a += atan_lut[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                a -= atan_lut[i];
            end
        end
        if (a > ANG_PI)
            a = ANG_PI;
        if (a < -ANG_PI)
            a = -ANG_PI;
        return a;
    endfunction

    function automatic logic [24:0] scale_angle(longint a);
        longint v;
        if (unit_deg)
            v = (a * DEG_MUL + (64'sd1 <<< 35)) >>> 36;
        else
            v = (a + 2048) >>> 12;
        return v[24:0];
    endfunction

    function automatic angles_t euler_of(logic [15:0] qw, logic [15:0] qx,
                                         logic [15:0] qy, logic [15:0] qz);
        longint w, x, y, z, s;
        longint unsigned c;
        angles_t r;
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        r.clamped = 1'b0;
        s = 2 * (w * y - x * z);
        if (s > ONE_Q28)
        begin
            s = ONE_Q28;
            r.clamped = 1'b1;
        end
        else if (s < -ONE_Q28)
        begin
            s = -ONE_Q28;
            r.clamped = 1'b1;
        end
        c = floor_sqrt(longint'(ONE_Q28) * ONE_Q28 - s * s);
        r.roll  = scale_angle(vector_angle(w * x + y * z, HALF_Q28 - x * x - y * y));
        r.pitch = scale_angle(vector_angle(s, longint'(c)));
        r.yaw   = scale_angle(vector_angle(x * y + w * z, HALF_Q28 - y * y - z * z));
        return r;
    endfunction

    // Offer one input word, with random idling before it, and wait for acceptance.
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit has_fixed, angles_t fixed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        angles_q.push_back(has_fixed ? fixed : euler_of(w, x, y, z));
        @(negedge clk);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (angles_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5)
            @(negedge clk);
    endtask

    task automatic write_unit(bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        unit_deg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(int count);
        logic [15:0] q[4];
        int mode;
        angles_t none;
        none = '{default: '0};
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(9);
            for (int k = 0; k < 4; k++)
            begin
                if (mode < 5)
                    q[k] = 16'($signed($urandom_range(32768)) - 16384);
                else if (mode < 8)
                    q[k] = 16'($urandom);
                else
                    q[k] = $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                             : 16'h8000 + 16'($urandom_range(3));
            end
            send_quat(q[0], q[1], q[2], q[3], 1'b0, none);
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker against the oldest expected word.
    always @(posedge clk)
    begin
        angles_t exp_a;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (angles_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", m_tdata);
            end
            else
            begin
                exp_a = angles_q.pop_front();
                if (m_tdata[24:0] !== exp_a.roll || m_tdata[49:25] !== exp_a.pitch ||
                    m_tdata[74:50] !== exp_a.yaw || m_tuser !== exp_a.clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r=%h p=%h y=%h c=%b got r=%h p=%h y=%h c=%b",
                                 exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.clamped,
                                 m_tdata[24:0], m_tdata[49:25], m_tdata[74:50], m_tuser);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        quat_row_t rows[$];
        angles_t zero_a;
        angles_t none;
        cycle_count   = 0;
        mismatches    = 0;
        hold_cycles   = 0;
        unit_deg      = 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 77;
        build_atan_lut();
        zero_a = '{default: '0};
        none   = zero_a;

        // Identity, zero, extremes of each field and clamped pitch cases.
        rows.push_back('{16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none});
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none});
        rows.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, none});
        rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, none});
        rows.push_back('{16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 1'b0, none});
        rows.push_back('{16'h8000, 16'h0000, 16'h7fff, 16'h0000, 1'b0, none});
        rows.push_back('{16'h0000, 16'h7fff, 16'h0000, 16'h8000, 1'b0, none});
        rows.push_back('{16'h2d41, 16'h0000, 16'h2d41, 16'h0000, 1'b0, none});
        rows.push_back('{16'h2d41, 16'h2d41, 16'h0000, 16'h0000, 1'b0, none});
        rows.push_back('{16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 1'b0, none});
        rows.push_back('{16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0, none});
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0, none});
        rows.push_back('{16'h0000, 16'hc000, 16'h0000, 16'h0000, 1'b0, none});
        rows.push_back('{16'h2000, 16'h2000, 16'h2000, 16'h2000, 1'b0, none});
        rows.push_back('{16'h2000, 16'he000, 16'h2000, 16'he000, 1'b0, none});
        rows.push_back('{16'h0001, 16'hffff, 16'h0001, 16'hffff, 1'b0, none});
        rows.push_back('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, none});

        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Degrees after reset, directed rows first.
        foreach (rows[i])
            send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].has_fixed, rows[i].fixed);
        random_burst(300);

        // Long receiver hold-off so the pipeline fills and stalls its input.
        hold_cycles = 200;
        random_burst(150);
        drain_and_idle();

        write_unit(1'b0);
        foreach (rows[i])
            send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].has_fixed, rows[i].fixed);
        random_burst(450);
        drain_and_idle();

        send_idle_pct = 77;
        recv_idle_pct = 12;
        write_unit(1'b1);
        random_burst(500);
        drain_and_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_unit(1'b0);
        random_burst(250);
        drain_and_idle();
        write_unit(1'b1);
        random_burst(250);
        drain_and_idle();

        if (mismatches == 0 && angles_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
